// ----- rtl/core/sfp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sfp_pkg;

  // Largest LEN accepted in a frame header
  localparam logic [7:0] MaxData = 8'd8;

  localparam logic [7:0] StartByte = 8'hEE;
  localparam logic [7:0] EscByte   = 8'hEA;
  localparam logic [7:0] EscStart  = 8'hEB;
  localparam logic [7:0] EscEsc    = 8'hEC;
  localparam logic [7:0] NotMask   = 8'hFF;

  localparam int unsigned OutWidth = 80;

  typedef enum logic [2:0] {
    StatusOk             = 3'd0,
    StatusUnknownCmd     = 3'd1,
    StatusCheckMismatch  = 3'd2,
    StatusBadEscape      = 3'd3,
    StatusNotLenMismatch = 3'd4,
    StatusLenOverLimit   = 3'd5
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [7:0]  command;
    logic [3:0]  data_count;
    logic [63:0] payload;
  } result_t;

  function automatic logic known_command(input logic [7:0] c);
    return (c >= 8'h01 && c <= 8'h04) || c == 8'h11 || c == 8'h22 ||
           c == 8'h33 || c == 8'h44 || c == 8'h55 || c == 8'h66;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sfp_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sfp_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  input  wire logic       advance_i,
  output logic            byte_valid_o,
  output logic [7:0]      byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  // the register frees up in the same cycle the core consumes it
  assign s_axis_tready = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      byte_q <= s_axis_tdata;
    end
  end

  assign byte_valid_o = valid_q;
  assign byte_o       = byte_q;

endmodule

`default_nettype wire

// ----- rtl/core/sfp_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sfp_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       advance_i,
  input  wire logic [7:0] byte_i,
  output logic            res_valid_o,
  output sfp_pkg::result_t res_o
);

  logic        in_frame_q, in_frame_d;
  logic [3:0]  pos_q, pos_d;
  logic [3:0]  len_q, len_d;
  logic        esc_q, esc_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [63:0] payload_q, payload_d;
  logic [11:0] parity_q, parity_d;
  logic [7:0]  chk_q, chk_d;

  logic            take;
  logic [7:0]      data_byte;
  logic [4:0]      data_end;
  logic [15:0]     check_word;
  logic [2:0]      slot;
  logic [3:0]      rcv_count;
  sfp_pkg::status_e status;

  assign data_end   = {1'b0, len_q} + 5'd4;
  // parity bits are left-aligned into the 16-bit check word
  assign check_word = {parity_q, 4'b0000} << (4'd8 - len_q);
  assign slot       = 3'(pos_q - 4'd4);
  assign rcv_count  = (pos_q <= 4'd4) ? 4'd0 :
                      ((pos_q - 4'd4) > len_q) ? len_q : (pos_q - 4'd4);

  always_comb begin
    in_frame_d  = in_frame_q;
    pos_d       = pos_q;
    len_d       = len_q;
    esc_d       = esc_q;
    cmd_d       = cmd_q;
    payload_d   = payload_q;
    parity_d    = parity_q;
    chk_d       = chk_q;
    take        = 1'b0;
    data_byte   = byte_i;
    res_valid_o = 1'b0;
    status      = sfp_pkg::StatusOk;

    if (advance_i) begin
      priority if (byte_i == sfp_pkg::StartByte) begin
        in_frame_d = 1'b1;
        pos_d      = 4'd1;
        len_d      = 4'd0;
        esc_d      = 1'b0;
        cmd_d      = 8'h00;
        payload_d  = 64'h0;
        parity_d   = {11'h000, ^sfp_pkg::StartByte};
        chk_d      = 8'h00;
      end else if (!in_frame_q) begin
        // idle: drop the byte
      end else if (pos_q <= 4'd1) begin
        if (byte_i > sfp_pkg::MaxData) begin
          res_valid_o = 1'b1;
          status      = sfp_pkg::StatusLenOverLimit;
        end else begin
          len_d    = byte_i[3:0];
          parity_d = {parity_q[10:0], ^byte_i};
          pos_d    = 4'd2;
        end
      end else if (pos_q == 4'd2) begin
        if ((byte_i ^ {4'h0, len_q}) != sfp_pkg::NotMask) begin
          res_valid_o = 1'b1;
          status      = sfp_pkg::StatusNotLenMismatch;
        end else begin
          parity_d = {parity_q[10:0], ^byte_i};
          pos_d    = 4'd3;
        end
      end else if (pos_q == 4'd3) begin
        cmd_d    = byte_i;
        parity_d = {parity_q[10:0], ^byte_i};
        pos_d    = 4'd4;
      end else begin
        // data and check bytes go through the unstuffing
        priority if (esc_q) begin
          esc_d = 1'b0;
          priority if (byte_i == sfp_pkg::EscStart) begin
            data_byte = sfp_pkg::StartByte;
            take      = 1'b1;
          end else if (byte_i == sfp_pkg::EscEsc) begin
            data_byte = sfp_pkg::EscByte;
            take      = 1'b1;
          end else begin
            res_valid_o = 1'b1;
            status      = sfp_pkg::StatusBadEscape;
          end
        end else if (byte_i == sfp_pkg::EscByte) begin
          esc_d = 1'b1;
        end else begin
          take = 1'b1;
        end

        if (take) begin
          pos_d = pos_q + 4'd1;
          priority if ({1'b0, pos_q} < data_end) begin
            payload_d[{slot, 3'b000} +: 8] = payload_q[{slot, 3'b000} +: 8] | data_byte;
            parity_d = {parity_q[10:0], ^data_byte};
          end else if ({1'b0, pos_q} == data_end) begin
            chk_d = data_byte;
          end else begin
            res_valid_o = 1'b1;
            if (chk_q != check_word[15:8] || data_byte != check_word[7:0]) begin
              status = sfp_pkg::StatusCheckMismatch;
            end else if (!sfp_pkg::known_command(cmd_q)) begin
              status = sfp_pkg::StatusUnknownCmd;
            end else begin
              status = sfp_pkg::StatusOk;
            end
          end
        end
      end
    end

    if (res_valid_o) begin
      in_frame_d = 1'b0;
      esc_d      = 1'b0;
    end
  end

  assign res_o.status     = status;
  assign res_o.command    = cmd_q;
  assign res_o.data_count = rcv_count;
  assign res_o.payload    = payload_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      pos_q      <= 4'd0;
      len_q      <= 4'd0;
      esc_q      <= 1'b0;
      cmd_q      <= 8'h00;
      payload_q  <= 64'h0;
      parity_q   <= 12'h000;
      chk_q      <= 8'h00;
    end else begin
      in_frame_q <= in_frame_d;
      pos_q      <= pos_d;
      len_q      <= len_d;
      esc_q      <= esc_d;
      cmd_q      <= cmd_d;
      payload_q  <= payload_d;
      parity_q   <= parity_d;
      chk_q      <= chk_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sfp_out_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sfp_out_stage (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            load_i,
  input  wire sfp_pkg::result_t                res_i,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [2:0] status, [10:3] command, [14:11] data_count, [78:15] payload, [79] zero
  output logic [sfp_pkg::OutWidth-1:0]         m_axis_tdata
);

  logic                          valid_q;
  logic [sfp_pkg::OutWidth-1:0]  data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= {1'b0, res_i.payload, res_i.data_count, res_i.command, res_i.status};
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;

endmodule

`default_nettype wire

// ----- rtl/core/stuffed_frame_parser_parity_check_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Byte-stream frame parser with escape decoding and a parity check word.
// Input stream (s_axis): one raw received byte per transfer, in tdata[7:0].
// Output stream (m_axis): one 80-bit result per completed or failed frame:
//   status, command, decoded data byte count and up to eight payload bytes.
// Frames are 0xEE, LEN, ~LEN, CMD, LEN data bytes and two check bytes;
// 0xEA 0xEB and 0xEA 0xEC in the data and check bytes decode to 0xEE / 0xEA.
// Throughput: one byte per cycle while no stalled result is held. Each byte
// passes an input register and is then folded into the frame state by the
// parser core, which also loads the result register, so a result shows on
// m_axis from that register once the core takes the byte that ends the frame.
// Bytes that produce no result (most of them) never touch the output side.
// If a result is still held because the receiver stalls, the core stops at
// the next byte; s_axis_tready then drops once the input register is full.
// Reset clears the frame state (waiting for 0xEE) and both stage valid flags.
module stuffed_frame_parser_parity_check_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,   // [7:0] rx_byte
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [2:0] status, [10:3] command, [14:11] data_count, [78:15] payload, [79] zero
  output logic [sfp_pkg::OutWidth-1:0]       m_axis_tdata
);

  logic             byte_valid;
  logic [7:0]       rx_byte;
  logic             advance;
  logic             res_valid;
  sfp_pkg::result_t res;

  assign advance = byte_valid && (!m_axis_tvalid || m_axis_tready);

  sfp_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .advance_i     (advance),
    .byte_valid_o  (byte_valid),
    .byte_o        (rx_byte)
  );

  sfp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .byte_i      (rx_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sfp_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (res_valid),
    .res_i         (res),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ----- rtl/core/sfp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sfp_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic [7:0]                    s_axis_tdata,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [sfp_pkg::OutWidth-1:0]  m_axis_tdata
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= sfp_pkg::StatusLenOverLimit &&
                      m_axis_tdata[14:11] <= sfp_pkg::MaxData[3:0])
    else $error("status or count out of range");

  // header errors happen before any data byte or command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[2:0] == sfp_pkg::StatusLenOverLimit ||
                      m_axis_tdata[2:0] == sfp_pkg::StatusNotLenMismatch)
    |-> m_axis_tdata[14:3] == 12'h000 && m_axis_tdata[78:15] == 64'h0)
    else $error("header error with command or payload");

  // every result needs at least a start byte and one more byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2) ||
                             $past(!s_axis_tready, 2) || $past(!s_axis_tready, 1) ||
                             $past(s_axis_tdata != sfp_pkg::StartByte, 2))
    else $error("result from a start byte");

endmodule

bind stuffed_frame_parser_parity_check_top sfp_checker u_sfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- tb/tb_stuffed_frame_parser_parity_check_top.sv -----
`timescale 1ns / 1ps

module tb_stuffed_frame_parser_parity_check_top;

  // command codes the parser accepts, lowest byte first
  localparam logic [79:0] KnownCmds = {8'h66, 8'h55, 8'h44, 8'h33, 8'h22,
                                       8'h11, 8'h04, 8'h03, 8'h02, 8'h01};
  localparam int NumKnownCmds = 10;
  localparam int HoldCycles   = 300;
  localparam int DrainCycles  = 10;
  localparam int RandomBytes  = 320;

  typedef enum int {
    FlawNone,
    FlawCheck,
    FlawNotLen,
    FlawLongLen,
    FlawBadEsc,
    FlawEscRestart,
    FlawCut
  } flaw_e;

  // Tracks frame state per accepted byte and holds the results still owed by the block.
  class frame_checker;
    bit                 in_frame;
    bit [3:0]           pos;
    bit [7:0]           len;
    bit                 esc;
    bit [7:0]           cmd;
    bit [63:0]          pay;
    bit [11:0]          par;
    bit [7:0]           chk_hi;
    sfp_pkg::result_t   expected_frames[$];
    int                 mismatch_count;

    function new();
      clear_frame();
      mismatch_count = 0;
    endfunction

    function void clear_frame();
      in_frame = 0;
      pos      = 0;
      len      = 0;
      esc      = 0;
      cmd      = 0;
      pay      = 0;
      par      = 0;
      chk_hi   = 0;
    endfunction

    function bit is_known_cmd(bit [7:0] c);
      bit hit;
      hit = 0;
      for (int i = 0; i < NumKnownCmds; i++) begin
        if (KnownCmds[8*i +: 8] == c) hit = 1;
      end
      return hit;
    endfunction

    function void shift_parity(bit [7:0] b);
      par = {par[10:0], ^b};
    endfunction

    function void close_frame(sfp_pkg::status_e st);
      sfp_pkg::result_t r;
      int               p;
      int               cnt;
      p   = pos;
      cnt = 0;
      if (p > 4) begin
        cnt = p - 4;
        if (cnt > len) cnt = len;
      end
      r.status     = st;
      r.command    = cmd;
      r.data_count = 4'(cnt);
      r.payload    = pay;
      expected_frames.push_back(r);
      in_frame = 0;
      esc      = 0;
    endfunction

    function void take_rx_byte(bit [7:0] b);
      bit [7:0]    d;
      int          p;
      int          n;
      int unsigned w;
      if (b == sfp_pkg::StartByte) begin
        clear_frame();
        in_frame = 1;
        pos      = 1;
        shift_parity(sfp_pkg::StartByte);
        return;
      end
      if (!in_frame) return;
      p = pos;
      if (p <= 1) begin
        if (b > sfp_pkg::MaxData) begin
          close_frame(sfp_pkg::StatusLenOverLimit);
          return;
        end
        len = b;
        shift_parity(b);
        pos = 2;
        return;
      end
      if (p == 2) begin
        if ((b ^ len) != sfp_pkg::NotMask) begin
          close_frame(sfp_pkg::StatusNotLenMismatch);
          return;
        end
        shift_parity(b);
        pos = 3;
        return;
      end
      if (p == 3) begin
        cmd = b;
        shift_parity(b);
        pos = 4;
        return;
      end
      // data and check bytes go through escape decoding
      if (esc) begin
        esc = 0;
        if (b == sfp_pkg::EscStart) d = sfp_pkg::StartByte;
        else if (b == sfp_pkg::EscEsc) d = sfp_pkg::EscByte;
        else begin
          close_frame(sfp_pkg::StatusBadEscape);
          return;
        end
      end else if (b == sfp_pkg::EscByte) begin
        esc = 1;
        return;
      end else begin
        d = b;
      end
      n = 4 + len;
      if (p < n) begin
        pay |= 64'(d) << (8 * ((p - 4) & 7));
        shift_parity(d);
        pos = pos + 1;
        return;
      end
      if (p == n) begin
        chk_hi = d;
        pos    = pos + 1;
        return;
      end
      w   = (int'(par) << (16 - n)) & 32'hFFFF;
      pos = pos + 1;
      if (chk_hi != w[15:8] || d != w[7:0]) close_frame(sfp_pkg::StatusCheckMismatch);
      else if (!is_known_cmd(cmd)) close_frame(sfp_pkg::StatusUnknownCmd);
      else close_frame(sfp_pkg::StatusOk);
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatch_count++;
    endtask

    task check_frame_result(logic [sfp_pkg::OutWidth-1:0] data);
      sfp_pkg::result_t want;
      if (expected_frames.size() == 0) begin
        report($sformatf("result with no frame pending, tdata=%h", data));
        return;
      end
      want = expected_frames.pop_front();
      if (data[2:0] !== want.status)
        report($sformatf("status %0d, want %0d", data[2:0], want.status));
      if (data[10:3] !== want.command)
        report($sformatf("command %h, want %h", data[10:3], want.command));
      if (data[14:11] !== want.data_count)
        report($sformatf("data_count %0d, want %0d", data[14:11], want.data_count));
      if (data[78:15] !== want.payload)
        report($sformatf("payload %h, want %h", data[78:15], want.payload));
      if (data[79] !== 1'b0)
        report("pad bit not zero");
    endtask
  endclass

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [7:0]                   s_axis_tdata  = 8'h00;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [sfp_pkg::OutWidth-1:0] m_axis_tdata;

  frame_checker sb = new();
  logic [7:0]   stim[$];
  int           sent_bytes = 0;
  bit           tx_fast    = 0;
  bit           rx_fast    = 0;
  bit           hold_req   = 0;

  stuffed_frame_parser_parity_check_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void push_escaped(logic [7:0] b);
    if (b == sfp_pkg::StartByte) begin
      stim.push_back(sfp_pkg::EscByte);
      stim.push_back(sfp_pkg::EscStart);
    end else if (b == sfp_pkg::EscByte) begin
      stim.push_back(sfp_pkg::EscByte);
      stim.push_back(sfp_pkg::EscEsc);
    end else begin
      stim.push_back(b);
    end
  endfunction

  function automatic void push_bad_escape(flaw_e flaw);
    logic [7:0] b;
    stim.push_back(sfp_pkg::EscByte);
    if (flaw == FlawEscRestart) begin
      stim.push_back(sfp_pkg::StartByte);
    end else begin
      do b = 8'($urandom); while (b == sfp_pkg::EscStart || b == sfp_pkg::EscEsc);
      stim.push_back(b);
    end
  endfunction

  // Appends one frame as raw line bytes; fill < 0 gives random data biased to escapes.
  function automatic void add_frame(int len, logic [7:0] cmd, flaw_e flaw, int fill);
    logic [7:0]  len_b;
    logic [7:0]  nlen_b;
    logic [7:0]  d;
    logic [15:0] w;
    int unsigned par_seq;
    int          bad_at;
    int          start;
    int          keep;
    start  = stim.size();
    len_b  = 8'(len);
    nlen_b = ~len_b;
    if (flaw == FlawLongLen) len_b = 8'($urandom_range(sfp_pkg::MaxData + 1, 255));
    if (flaw == FlawNotLen) nlen_b ^= 8'($urandom_range(1, 255));
    par_seq = ^sfp_pkg::StartByte;
    par_seq = (par_seq << 1) | (^len_b);
    par_seq = (par_seq << 1) | (^nlen_b);
    par_seq = (par_seq << 1) | (^cmd);
    stim.push_back(sfp_pkg::StartByte);
    stim.push_back(len_b);
    stim.push_back(nlen_b);
    stim.push_back(cmd);
    bad_at = (flaw == FlawBadEsc || flaw == FlawEscRestart) ? $urandom_range(0, len) : -1;
    for (int i = 0; i < len; i++) begin
      if (i == bad_at) push_bad_escape(flaw);
      if (fill >= 0) d = 8'(fill);
      else begin
        case ($urandom_range(0, 5))
          0:       d = sfp_pkg::StartByte;
          1:       d = sfp_pkg::EscByte;
          default: d = 8'($urandom);
        endcase
      end
      par_seq = (par_seq << 1) | (^d);
      push_escaped(d);
    end
    if (bad_at == len) push_bad_escape(flaw);
    w = 16'(par_seq << (16 - (4 + len)));
    if (flaw == FlawCheck) w ^= 16'(1 << $urandom_range(0, 15));
    push_escaped(w[15:8]);
    push_escaped(w[7:0]);
    if (flaw == FlawCut) begin
      keep = $urandom_range(1, stim.size() - start - 1);
      while (stim.size() > start + keep) void'(stim.pop_back());
    end
  endfunction

  function automatic logic [7:0] pick_cmd();
    if ($urandom_range(0, 3) != 0)
      return KnownCmds[8 * $urandom_range(0, NumKnownCmds - 1) +: 8];
    return 8'($urandom);
  endfunction

  function automatic void add_random_sequence();
    int r;
    int len;
    r   = $urandom_range(0, 99);
    len = $urandom_range(0, sfp_pkg::MaxData);
    if (r < 55)      add_frame(len, pick_cmd(), FlawNone, -1);
    else if (r < 65) add_frame(len, pick_cmd(), FlawCheck, -1);
    else if (r < 72) add_frame(len, pick_cmd(), FlawNotLen, -1);
    else if (r < 77) add_frame(len, pick_cmd(), FlawLongLen, -1);
    else if (r < 85) add_frame(len, pick_cmd(), FlawBadEsc, -1);
    else if (r < 90) add_frame(len, pick_cmd(), FlawEscRestart, -1);
    else if (r < 95) add_frame(len, pick_cmd(), FlawCut, -1);
    else begin
      repeat ($urandom_range(1, 4)) stim.push_back(8'($urandom));
    end
  endfunction

  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_rx_byte(b);
    sent_bytes++;
  endtask

  task automatic send_all();
    while (stim.size() > 0) send_byte(stim.pop_front());
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.expected_frames.size() != 0);
  endtask

  // result side: per-cycle ready control with random stalls and one long hold
  initial begin
    int rx_wait;
    int hold_left;
    rx_wait   = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
        sb.check_frame_result(m_axis_tdata);
        rx_wait = rx_fast ? 0 : $urandom_range(0, 5);
        if ($urandom_range(0, 7) == 0) rx_fast = !rx_fast;
      end
      if (hold_req) begin
        hold_req  = 0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    bit paused;
    paused = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // idle noise, header errors, a zero-length frame, escapes, restarts
    stim.push_back(8'h00);
    stim.push_back(8'hFF);
    stim.push_back(sfp_pkg::StartByte);
    stim.push_back(sfp_pkg::MaxData + 8'd1);
    stim.push_back(sfp_pkg::StartByte);
    stim.push_back(8'h03);
    stim.push_back(8'h00);
    add_frame(0, 8'h55, FlawNone, -1);
    add_frame(1, 8'h99, FlawNone, sfp_pkg::StartByte);
    stim.push_back(sfp_pkg::StartByte);
    stim.push_back(8'h01);
    stim.push_back(8'hFE);
    stim.push_back(8'h11);
    stim.push_back(sfp_pkg::EscByte);
    stim.push_back(8'h00);
    // escape pending when a start byte arrives
    stim.push_back(sfp_pkg::StartByte);
    stim.push_back(8'h02);
    stim.push_back(8'hFD);
    stim.push_back(8'h11);
    stim.push_back(sfp_pkg::EscByte);
    add_frame(sfp_pkg::MaxData, 8'h66, FlawNone, 8'hFF);
    send_all();
    wait_drained();

    // back up the output while short error frames keep coming
    tx_fast  = 1;
    hold_req = 1;
    repeat (12) begin
      stim.push_back(sfp_pkg::StartByte);
      stim.push_back(8'($urandom_range(sfp_pkg::MaxData + 1, 255)));
    end
    send_all();
    tx_fast = 0;

    sent_bytes = 0;
    while (sent_bytes < RandomBytes) begin
      if ($urandom_range(0, 4) == 0) tx_fast = !tx_fast;
      add_random_sequence();
      send_all();
      if (!paused && sent_bytes > RandomBytes / 2) begin
        paused = 1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TIMEOUT with %0d results outstanding", sb.expected_frames.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
